/* hw/rtl/lkc_pkg.sv */
// Shared types and constants for the LRU keyed cache with batch eviction.
// Holds the controller state type and the controller/datapath command and status structs.
// No dependencies.
package lkc_pkg;

   localparam int KEY_W   = 32;
   localparam int STAMP_W = 32;
   localparam int SLOT_W  = 6;

   localparam logic KIND_EVICT  = 1'b0;
   localparam logic KIND_ANSWER = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_HIT,
      ST_PRUNE,
      ST_EVICT,
      ST_INSERT
   } ctl_state_type;

   typedef enum logic {
      SCAN_LOOKUP,
      SCAN_PRUNE
   } scan_mode_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] decl;
      logic [KEY_W-1:0] prog;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic          clear_en;
      logic          load_key;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          evict;
      logic          hit_answer;
      logic          insert_answer;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic hit_found;
      logic free_found;
      logic old_found;
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/lkc_if.sv */
// Valid/ready channel interfaces for the lookup request and result beats.
// Depends on lkc_pkg for field widths.
interface lkc_req_if;
   logic                        valid;
   logic                        ready;
   logic [lkc_pkg::KEY_W-1:0]   buffer_decl_id;
   logic [lkc_pkg::KEY_W-1:0]   program_id;

   modport source (output valid, buffer_decl_id, program_id, input ready);
   modport sink   (input valid, buffer_decl_id, program_id, output ready);
endinterface

interface lkc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        result_kind;
   logic [lkc_pkg::SLOT_W-1:0]  slot_index;
   logic [lkc_pkg::KEY_W-1:0]   evicted_decl_id;
   logic [lkc_pkg::KEY_W-1:0]   evicted_program_id;
   logic                        was_hit;
   logic                        is_last;

   modport source (output valid, result_kind, slot_index, evicted_decl_id,
                   evicted_program_id, was_hit, is_last, input ready);
   modport sink   (input valid, result_kind, slot_index, evicted_decl_id,
                   evicted_program_id, was_hit, is_last, output ready);
endinterface

/* hw/rtl/lkc_datapath.sv */
// Datapath: entry and stamp memories, scan engine, use counter and result register.
// Depends on lkc_pkg; driven by lkc_ctrl through cmd_type / sts_type.
module lkc_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkc_pkg::cmd_type              cmd,
   output lkc_pkg::sts_type              sts,
   input  logic [lkc_pkg::KEY_W-1:0]     key_decl,
   input  logic [lkc_pkg::KEY_W-1:0]     key_prog,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_result_kind,
   output logic [lkc_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [lkc_pkg::KEY_W-1:0]     rsp_evicted_decl_id,
   output logic [lkc_pkg::KEY_W-1:0]     rsp_evicted_program_id,
   output logic                          rsp_was_hit,
   output logic                          rsp_is_last
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   lkc_pkg::entry_type                key_mem   [CAPACITY];
   logic [lkc_pkg::STAMP_W-1:0]       stamp_mem [CAPACITY];

   lkc_pkg::entry_type                key_rd_ff;
   logic [lkc_pkg::STAMP_W-1:0]       stamp_rd_ff;

   logic                              key_we;
   logic [IDX_W-1:0]                  key_waddr;
   lkc_pkg::entry_type                key_wdata;
   logic                              stamp_we;
   logic [IDX_W-1:0]                  stamp_waddr;
   logic [lkc_pkg::STAMP_W-1:0]       stamp_wdata;

   logic [IDX_W-1:0]                  addr_ff;
   logic                              busy_ff;
   lkc_pkg::scan_mode_type            mode_ff;
   logic                              rd_vld_ff;
   logic                              rd_last_ff;
   logic [IDX_W-1:0]                  rd_idx_ff;
   logic                              done_ff;

   logic [lkc_pkg::KEY_W-1:0]         key_decl_ff;
   logic [lkc_pkg::KEY_W-1:0]         key_prog_ff;
   logic [lkc_pkg::STAMP_W-1:0]       use_counter_ff;

   logic                              hit_found_ff;
   logic [IDX_W-1:0]                  hit_idx_ff;
   logic                              ins_found_ff;
   logic [IDX_W-1:0]                  ins_idx_ff;
   logic                              old_found_ff;
   logic [IDX_W-1:0]                  old_idx_ff;
   logic [lkc_pkg::STAMP_W-1:0]       old_stamp_ff;
   logic [lkc_pkg::KEY_W-1:0]         old_decl_ff;
   logic [lkc_pkg::KEY_W-1:0]         old_prog_ff;

   logic                              rsp_valid_ff;
   logic                              kind_ff;
   logic [lkc_pkg::SLOT_W-1:0]        slot_ff;
   logic [lkc_pkg::KEY_W-1:0]         ev_decl_ff;
   logic [lkc_pkg::KEY_W-1:0]         ev_prog_ff;
   logic                              hit_ff;
   logic                              last_ff;

   logic                              out_free;
   logic                              key_match;
   logic                              older;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign key_match = key_rd_ff.valid && (key_rd_ff.decl == key_decl_ff)
                      && (key_rd_ff.prog == key_prog_ff);
   assign older     = key_rd_ff.valid && (!old_found_ff || (stamp_rd_ff < old_stamp_ff));

   // write port select: clearing pass, eviction, insertion, hit restamp
   always_comb begin
      key_we      = 1'b0;
      key_waddr   = addr_ff;
      key_wdata   = '0;
      stamp_we    = 1'b0;
      stamp_waddr = hit_idx_ff;
      stamp_wdata = use_counter_ff + lkc_pkg::STAMP_W'(1);
      if (cmd.clear_en) begin
         key_we = 1'b1;
      end else if (cmd.evict) begin
         key_we    = 1'b1;
         key_waddr = old_idx_ff;
      end else if (cmd.insert_answer) begin
         key_we          = 1'b1;
         key_waddr       = ins_idx_ff;
         key_wdata.valid = 1'b1;
         key_wdata.decl  = key_decl_ff;
         key_wdata.prog  = key_prog_ff;
         stamp_we        = 1'b1;
         stamp_waddr     = ins_idx_ff;
         stamp_wdata     = use_counter_ff + lkc_pkg::STAMP_W'(2);
      end
      if (cmd.hit_answer) begin
         stamp_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rd_ff <= key_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[stamp_waddr] <= stamp_wdata;
      end
      stamp_rd_ff <= stamp_mem[addr_ff];
   end

   // scan engine: one address a cycle; the read data is compared once registered
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         busy_ff    <= 1'b0;
         mode_ff    <= lkc_pkg::SCAN_LOOKUP;
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         rd_vld_ff  <= busy_ff;
         rd_last_ff <= busy_ff && (addr_ff == LAST_IDX);
         done_ff    <= rd_vld_ff && rd_last_ff;
         if (cmd.scan_start) begin
            busy_ff <= 1'b1;
            addr_ff <= '0;
            mode_ff <= cmd.scan_mode;
         end else if (busy_ff || cmd.clear_en) begin
            addr_ff <= (addr_ff == LAST_IDX) ? '0 : addr_ff + IDX_W'(1);
            if (addr_ff == LAST_IDX) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
   end

   // trackers: first match, lowest free slot, oldest stamp
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff <= 1'b0;
         ins_found_ff <= 1'b0;
         old_found_ff <= 1'b0;
      end else begin
         if (cmd.scan_start && (cmd.scan_mode == lkc_pkg::SCAN_LOOKUP)) begin
            hit_found_ff <= 1'b0;
            ins_found_ff <= 1'b0;
         end else if (cmd.scan_start) begin
            old_found_ff <= 1'b0;
         end else if (rd_vld_ff && (mode_ff == lkc_pkg::SCAN_LOOKUP)) begin
            if (key_match && !hit_found_ff) begin
               hit_found_ff <= 1'b1;
               hit_idx_ff   <= rd_idx_ff;
            end
            if (!key_rd_ff.valid && !ins_found_ff) begin
               ins_found_ff <= 1'b1;
               ins_idx_ff   <= rd_idx_ff;
            end
         end else if (rd_vld_ff && older) begin
            old_found_ff <= 1'b1;
            old_idx_ff   <= rd_idx_ff;
            old_stamp_ff <= stamp_rd_ff;
            old_decl_ff  <= key_rd_ff.decl;
            old_prog_ff  <= key_rd_ff.prog;
         end
         if (cmd.evict && (!ins_found_ff || (old_idx_ff < ins_idx_ff))) begin
            ins_found_ff <= 1'b1;
            ins_idx_ff   <= old_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_decl_ff <= key_decl;
         key_prog_ff <= key_prog;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_counter_ff <= '0;
      end else if (cmd.hit_answer) begin
         use_counter_ff <= use_counter_ff + lkc_pkg::STAMP_W'(1);
      end else if (cmd.insert_answer) begin
         use_counter_ff <= use_counter_ff + lkc_pkg::STAMP_W'(2);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.evict || cmd.hit_answer || cmd.insert_answer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.evict) begin
         kind_ff    <= lkc_pkg::KIND_EVICT;
         slot_ff    <= lkc_pkg::SLOT_W'(old_idx_ff);
         ev_decl_ff <= old_decl_ff;
         ev_prog_ff <= old_prog_ff;
         hit_ff     <= 1'b0;
         last_ff    <= 1'b0;
      end else if (cmd.hit_answer) begin
         kind_ff    <= lkc_pkg::KIND_ANSWER;
         slot_ff    <= lkc_pkg::SLOT_W'(hit_idx_ff);
         ev_decl_ff <= '0;
         ev_prog_ff <= '0;
         hit_ff     <= 1'b1;
         last_ff    <= 1'b1;
      end else if (cmd.insert_answer) begin
         kind_ff    <= lkc_pkg::KIND_ANSWER;
         slot_ff    <= lkc_pkg::SLOT_W'(ins_idx_ff);
         ev_decl_ff <= '0;
         ev_prog_ff <= '0;
         hit_ff     <= 1'b0;
         last_ff    <= 1'b1;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_kind        = kind_ff;
   assign rsp_slot_index         = slot_ff;
   assign rsp_evicted_decl_id    = ev_decl_ff;
   assign rsp_evicted_program_id = ev_prog_ff;
   assign rsp_was_hit            = hit_ff;
   assign rsp_is_last            = last_ff;

   assign sts.clear_done = (addr_ff == LAST_IDX);
   assign sts.scan_done  = done_ff;
   assign sts.hit_found  = hit_found_ff;
   assign sts.free_found = ins_found_ff;
   assign sts.old_found  = old_found_ff;
   assign sts.out_free   = out_free;

   a_load_needs_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.evict || cmd.hit_answer || cmd.insert_answer) |-> out_free)
      else $error("result loaded over a beat not yet taken");

   a_insert_has_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.insert_answer |-> ins_found_ff)
      else $error("insertion without a free slot");

   a_evict_has_victim: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> old_found_ff)
      else $error("eviction without a victim");

   a_done_after_scan: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(rd_vld_ff))
      else $error("scan done raised while still scanning");

endmodule

/* hw/rtl/lkc_ctrl.sv */
// Controller state machine: clearing pass, lookup scan, hit answer, prune rounds, insertion.
// Depends on lkc_pkg; drives lkc_datapath through cmd_type / sts_type.
module lkc_ctrl #(
   parameter int PRUNE_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output lkc_pkg::cmd_type  cmd,
   input  lkc_pkg::sts_type  sts
);

   localparam int PC_W = (PRUNE_COUNT > 1) ? $clog2(PRUNE_COUNT) : 1;
   localparam logic [PC_W-1:0] PC_LAST = PC_W'(PRUNE_COUNT - 1);

   lkc_pkg::ctl_state_type state_ff, state_in;
   logic [PC_W-1:0]        prune_cnt_ff, prune_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkc_pkg::ST_CLEAR;
         prune_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         prune_cnt_ff <= prune_cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      prune_cnt_in = prune_cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         lkc_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = lkc_pkg::ST_IDLE;
            end
         end
         lkc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_key   = 1'b1;
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = lkc_pkg::SCAN_LOOKUP;
               state_in       = lkc_pkg::ST_LOOKUP;
            end
         end
         lkc_pkg::ST_LOOKUP: begin
            if (sts.scan_done) begin
               if (sts.hit_found) begin
                  state_in = lkc_pkg::ST_HIT;
               end else if (sts.free_found) begin
                  state_in = lkc_pkg::ST_INSERT;
               end else begin
                  prune_cnt_in   = '0;
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = lkc_pkg::SCAN_PRUNE;
                  state_in       = lkc_pkg::ST_PRUNE;
               end
            end
         end
         lkc_pkg::ST_HIT: begin
            if (sts.out_free) begin
               cmd.hit_answer = 1'b1;
               state_in       = lkc_pkg::ST_IDLE;
            end
         end
         lkc_pkg::ST_PRUNE: begin
            if (sts.scan_done) begin
               state_in = sts.old_found ? lkc_pkg::ST_EVICT : lkc_pkg::ST_INSERT;
            end
         end
         lkc_pkg::ST_EVICT: begin
            if (sts.out_free) begin
               cmd.evict = 1'b1;
               if (prune_cnt_ff == PC_LAST) begin
                  state_in = lkc_pkg::ST_INSERT;
               end else begin
                  prune_cnt_in   = prune_cnt_ff + PC_W'(1);
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = lkc_pkg::SCAN_PRUNE;
                  state_in       = lkc_pkg::ST_PRUNE;
               end
            end
         end
         lkc_pkg::ST_INSERT: begin
            if (sts.out_free) begin
               cmd.insert_answer = 1'b1;
               state_in          = lkc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lkc_pkg::ST_IDLE;
         end
      endcase
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lkc_pkg::ST_CLEAR) |-> !req_ready && !cmd.scan_start)
      else $error("lookup started during clearing pass");

   a_prune_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lkc_pkg::ST_PRUNE || state_ff == lkc_pkg::ST_EVICT)
      |-> prune_cnt_ff <= PC_LAST)
      else $error("prune round count overran");

   a_answer_ends_item: assert property (@(posedge clock) disable iff (reset)
      (cmd.hit_answer || cmd.insert_answer) |=> state_ff == lkc_pkg::ST_IDLE)
      else $error("answer issued without returning to idle");

endmodule

/* hw/rtl/lru_keyed_cache_batch_evict_unit.sv */
// Top level of the fully associative LRU cache keyed by (buffer_decl_id, program_id).
// Depends on lkc_pkg, lkc_if, lkc_ctrl and lkc_datapath.
//
// Usage: req_if carries one lookup beat per key pair. rsp_if returns, per lookup, zero
//   or more eviction report beats (result_kind = 0), then one answer beat
//   (result_kind = 1, is_last = 1) giving the slot and whether the key hit. Items are
//   handled one at a time: req_if.ready is high only while the controller is idle,
//   which it may already be while the last answer still waits in the result register.
// Scanning: every lookup scans the entry memory one slot a cycle through its single
//   read port. A miss on a full store adds one stamp scan per eviction, for up to
//   PRUNE_COUNT evictions; the memory read port sets the rate.
// Reset: synchronous reset clears the use counter and control, then runs a clearing
//   pass over every slot of the entry memory, writing every valid flag low; no
//   lookup is accepted until it ends.
// Stalls: while rsp_if.ready is low the result register holds its beat and the
//   controller holds before loading the next one; no beat is dropped or repeated.
module lru_keyed_cache_batch_evict_unit #(
   parameter int CAPACITY    = 64,
   parameter int PRUNE_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   lkc_req_if.sink     req_if,
   lkc_rsp_if.source   rsp_if
);

   lkc_pkg::cmd_type cmd;
   lkc_pkg::sts_type sts;

   // sequencing: clear, scan, prune, insert
   lkc_ctrl #(
      .PRUNE_COUNT (PRUNE_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // memories, trackers and result register
   lkc_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .key_decl               (req_if.buffer_decl_id),
      .key_prog               (req_if.program_id),
      .rsp_valid              (rsp_if.valid),
      .rsp_ready              (rsp_if.ready),
      .rsp_result_kind        (rsp_if.result_kind),
      .rsp_slot_index         (rsp_if.slot_index),
      .rsp_evicted_decl_id    (rsp_if.evicted_decl_id),
      .rsp_evicted_program_id (rsp_if.evicted_program_id),
      .rsp_was_hit            (rsp_if.was_hit),
      .rsp_is_last            (rsp_if.is_last)
   );

endmodule

/* tb/tb.sv */
// Self-checking testbench for lru_keyed_cache_batch_evict_unit: a table of directed lookups,
// then random key pairs that fill the store and force batch evictions, scored beat by beat.
// Depends on lkc_pkg, lkc_if and the RTL of the unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 64;
   localparam int PRUNE_COUNT  = 8;
   localparam int RANDOM_ITEMS = 335;
   localparam int SCAN_CYCLES  = CAPACITY + 4;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int N_DIRECTED   = 15;

   // One result beat as the scoreboard holds it.
   typedef struct packed {
      logic                       kind;
      logic [lkc_pkg::SLOT_W-1:0] slot;
      logic [lkc_pkg::KEY_W-1:0]  decl;
      logic [lkc_pkg::KEY_W-1:0]  prog;
      logic                       hit;
      logic                       last;
   } rsp_beat_type;

   // One directed lookup; where pinned, the answer slot and hit flag are typed in here.
   typedef struct {
      logic [lkc_pkg::KEY_W-1:0] decl;
      logic [lkc_pkg::KEY_W-1:0] prog;
      bit                        pinned;
      int unsigned               slot;
      bit                        hit;
   } lookup_row_type;

   logic clock;
   logic reset;

   lkc_req_if req_if();
   lkc_rsp_if rsp_if();

   lru_keyed_cache_batch_evict_unit #(
      .CAPACITY    (CAPACITY),
      .PRUNE_COUNT (PRUNE_COUNT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Shadow copy of the cache contents and the use counter.
   logic                          shadow_valid [CAPACITY];
   logic [lkc_pkg::KEY_W-1:0]     shadow_decl  [CAPACITY];
   logic [lkc_pkg::KEY_W-1:0]     shadow_prog  [CAPACITY];
   logic [lkc_pkg::STAMP_W-1:0]   shadow_stamp [CAPACITY];
   logic [lkc_pkg::STAMP_W-1:0]   shadow_uses;

   rsp_beat_type   beats_due [$];
   logic [63:0]    seen_keys [$];
   lookup_row_type directed_rows [N_DIRECTED];

   int          mismatch_count = 0;
   int unsigned cycle_count    = 0;
   bit          req_burst      = 1'b0;
   bit          rsp_burst      = 1'b0;

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: give up well past the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  beats_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic rsp_beat_type beat_of(input logic kind, input int slot,
                                            input logic [lkc_pkg::KEY_W-1:0] decl, prog,
                                            input logic hit, last);
      rsp_beat_type b;
      b.kind = kind;
      b.slot = lkc_pkg::SLOT_W'(slot);
      b.decl = decl;
      b.prog = prog;
      b.hit  = hit;
      b.last = last;
      return b;
   endfunction

   // Append one beat to the tail of the due list.
   function automatic void enqueue_beat(input rsp_beat_type b);
      beats_due.insert(beats_due.size(), b);
   endfunction

   // Remember a key for later reuse; keep only the most recent ones.
   function automatic void remember_key(input logic [63:0] pair);
      seen_keys.insert(seen_keys.size(), pair);
      if (seen_keys.size() > 96)
         void'(seen_keys.pop_front());
   endfunction

   // Work out the beats one lookup causes and queue them; update the shadow store.
   task automatic predict_lookup(input logic [lkc_pkg::KEY_W-1:0] decl, prog);
      int hit_slot;
      int free_slot;
      int oldest;
      int used;
      hit_slot  = -1;
      free_slot = -1;
      used      = 0;
      // Lowest matching valid slot wins; unwritten slots are never read.
      for (int i = 0; i < CAPACITY; i++) begin
         if (shadow_valid[i]) begin
            used++;
            if (hit_slot < 0 && shadow_decl[i] == decl && shadow_prog[i] == prog)
               hit_slot = i;
         end
      end
      if (hit_slot >= 0) begin
         // Hit: one tick of the counter, fresh stamp.
         shadow_uses            = shadow_uses + 1;
         shadow_stamp[hit_slot] = shadow_uses;
         enqueue_beat(beat_of(lkc_pkg::KIND_ANSWER, hit_slot, '0, '0, 1'b1, 1'b1));
         return;
      end
      if (used >= CAPACITY) begin
         // Full store: evict the oldest stamps in ascending order, lowest slot on a tie.
         for (int n = 0; n < PRUNE_COUNT; n++) begin
            oldest = -1;
            for (int i = 0; i < CAPACITY; i++)
               if (shadow_valid[i] && (oldest < 0 || shadow_stamp[i] < shadow_stamp[oldest]))
                  oldest = i;
            if (oldest < 0)
               break;
            shadow_valid[oldest] = 1'b0;
            enqueue_beat(beat_of(lkc_pkg::KIND_EVICT, oldest, shadow_decl[oldest],
                                 shadow_prog[oldest], 1'b0, 1'b0));
         end
      end
      for (int i = 0; i < CAPACITY; i++)
         if (free_slot < 0 && !shadow_valid[i])
            free_slot = i;
      // Miss: the counter moves twice, the entry keeps the second value.
      shadow_uses             = shadow_uses + 2;
      shadow_valid[free_slot] = 1'b1;
      shadow_decl[free_slot]  = decl;
      shadow_prog[free_slot]  = prog;
      shadow_stamp[free_slot] = shadow_uses;
      enqueue_beat(beat_of(lkc_pkg::KIND_ANSWER, free_slot, '0, '0, 1'b0, 1'b1));
   endtask

   // Present one lookup beat after a random gap and hold it until accepted.
   task automatic send_lookup(input logic [lkc_pkg::KEY_W-1:0] decl, prog, input bit pinned,
                              input int unsigned pin_slot, input bit pin_hit);
      int unsigned  gap;
      rsp_beat_type answer;
      if ($urandom_range(0, 15) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.buffer_decl_id <= decl;
      req_if.program_id     <= prog;
      do @(posedge clock); while (!req_if.ready);
      predict_lookup(decl, prog);
      // Swap in the typed-in answer for table rows that carry one.
      if (pinned) begin
         answer      = beats_due.pop_back();
         answer.slot = lkc_pkg::SLOT_W'(pin_slot);
         answer.hit  = pin_hit;
         enqueue_beat(answer);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Score every accepted result beat against the oldest one due.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (beats_due.size() == 0) begin
            $error("result beat with no lookup pending: slot %0d kind %0b",
                   rsp_if.slot_index, rsp_if.result_kind);
            mismatch_count++;
         end else begin
            want = beats_due.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(rsp_if.result_kind));
            check_field("slot_index", 32'(want.slot), 32'(rsp_if.slot_index));
            check_field("evicted_decl_id", want.decl, rsp_if.evicted_decl_id);
            check_field("evicted_program_id", want.prog, rsp_if.evicted_program_id);
            check_field("was_hit", 32'(want.hit), 32'(rsp_if.was_hit));
            check_field("is_last", 32'(want.last), 32'(rsp_if.is_last));
         end
      end
   end

   // Result side: stall a random number of cycles once a beat is offered, with bursts of
   // back-to-back acceptance.
   initial begin
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            do @(posedge clock); while (!rsp_if.valid);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // Main sequence: reset, directed table, random lookups, drain.
   initial begin
      int unsigned pick;
      logic [63:0] pair;
      logic [lkc_pkg::KEY_W-1:0] decl;
      logic [lkc_pkg::KEY_W-1:0] prog;

      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.buffer_decl_id <= '0;
      req_if.program_id     <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_decl[i]  = '0;
         shadow_prog[i]  = '0;
         shadow_stamp[i] = '0;
      end
      shadow_uses = '0;

      // Fresh store fills from slot 0 upward; repeats hit their old slot. Keys sharing one
      // half with a stored key must miss.
      directed_rows = '{
         '{32'h0000_0000, 32'h0000_0000, 1'b1, 0, 1'b0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 1'b0},
         '{32'h0000_0000, 32'h0000_0000, 1'b1, 0, 1'b1},
         '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 2, 1'b0},
         '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 3, 1'b0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 1'b1},
         '{32'h0000_0001, 32'h0000_0000, 1'b1, 4, 1'b0},
         '{32'h8000_0000, 32'h0000_0001, 1'b1, 5, 1'b0},
         '{32'h0000_0000, 32'h8000_0000, 1'b1, 6, 1'b0},
         '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 2, 1'b1},
         '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 7, 1'b0},
         '{32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, 8, 1'b0},
         '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 7, 1'b1},
         '{32'h0000_0001, 32'h0000_0000, 1'b1, 4, 1'b1},
         '{32'h0000_0001, 32'h0000_0001, 1'b1, 9, 1'b0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The unit runs its clearing pass first; send_lookup simply waits for ready.
      foreach (directed_rows[r]) begin
         send_lookup(directed_rows[r].decl, directed_rows[r].prog, directed_rows[r].pinned,
                     directed_rows[r].slot, directed_rows[r].hit);
         remember_key({directed_rows[r].decl, directed_rows[r].prog});
      end

      // Random part: just over half fresh keys, so the store fills and later misses on a full
      // store evict a batch; reuse recent keys so some hit and some find themselves evicted.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         decl = $urandom;
         prog = $urandom;
         pair = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
         if (pick < 45) begin
            decl = pair[63:32];
            prog = pair[31:0];
         end else if (pick < 55) begin
            // Match one half only: must miss.
            if (pick[0])
               decl = pair[63:32];
            else
               prog = pair[31:0];
         end else if (pick < 60) begin
            decl = $urandom_range(0, 2);
            prog = $urandom_range(0, 2);
         end
         send_lookup(decl, prog, 1'b0, 0, 1'b0);
         remember_key({decl, prog});
      end
      req_if.valid <= 1'b0;

      // Drain, then keep the clock running so that any stray beat shows.
      while (beats_due.size() != 0) @(posedge clock);
      repeat (2 * SCAN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && beats_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (beats_due.size() != 0)
            $error("%0d result beats never arrived", beats_due.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
